// ===== rtl/core/cte_pkg.sv =====
package cte_pkg;

    // key codes
    localparam logic [3:0] KEY_CONFIRM = 4'd10;
    localparam logic [3:0] KEY_LEFT    = 4'd11;
    localparam logic [3:0] KEY_RIGHT   = 4'd12;
    localparam logic [3:0] KEY_UP      = 4'd13;
    localparam logic [3:0] KEY_DOWN    = 4'd14;
    localparam logic [3:0] KEY_NONE    = 4'd15;
    localparam logic [3:0] KEY_DIGIT_LIMIT_HOUR_TENS = 4'd2;
    localparam logic [3:0] KEY_DIGIT_LIMIT_HOUR_UNITS = 4'd3;
    localparam logic [3:0] KEY_DIGIT_LIMIT_TENS = 4'd5;

    // cursor positions
    localparam logic [2:0] POS_HOUR_TENS  = 3'd0;
    localparam logic [2:0] POS_HOUR_UNITS = 3'd1;
    localparam logic [2:0] POS_MIN_TENS   = 3'd2;
    localparam logic [2:0] POS_MIN_UNITS  = 3'd3;
    localparam logic [2:0] POS_SEC_TENS   = 3'd4;
    localparam logic [2:0] POS_SEC_UNITS  = 3'd5;
    localparam logic [2:0] LAST_POS       = POS_SEC_UNITS;

    // field limits
    localparam logic [5:0] HOUR_MAX      = 6'd23;
    localparam logic [5:0] MINSEC_MAX    = 6'd59;
    localparam logic [5:0] HOUR_TENS_TOP = 6'd20;
    localparam logic [5:0] MINSEC_TENS_TOP = 6'd50;
    localparam logic [5:0] TEN           = 6'd10;
    localparam logic [4:0] HOURS_EDIT_MAX = 5'd29;

    typedef struct packed {
        logic       mode;
        logic [3:0] key;
        logic [7:0] load_hours_bcd;
        logic [7:0] load_minutes_bcd;
        logic [7:0] load_seconds_bcd;
    } t_req;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
    } t_state;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
        logic       commit;
        logic [7:0] hours_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] seconds_bcd;
    } t_result;

    // tens digit of a value below 64 by compare chain
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [5:0] tens_times_ten(input logic [5:0] v);
        return 6'(6'(tens_of(v)) * TEN);
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - tens_times_ten(v);
        return r[3:0];
    endfunction

    function automatic logic [7:0] to_packed(input logic [5:0] v);
        return {1'b0, tens_of(v), units_of(v)};
    endfunction

    // packed decimal byte to binary, saturated at the field limit
    function automatic logic [5:0] from_packed(input logic [7:0] b, input logic [5:0] limit);
        logic [7:0] v;
        v = 8'(8'(b[7:4]) * 8'd10) + 8'(b[3:0]);
        return (v > 8'(limit)) ? limit : v[5:0];
    endfunction

endpackage

// ===== rtl/core/cte_if.sv =====
interface cte_req_if;
    import cte_pkg::*;
    logic valid;
    logic ready;
    logic       mode;
    logic [3:0] key;
    logic [7:0] load_hours_bcd;
    logic [7:0] load_minutes_bcd;
    logic [7:0] load_seconds_bcd;

    modport source (output valid, mode, key, load_hours_bcd, load_minutes_bcd,
                    load_seconds_bcd, input ready);
    modport sink (input valid, mode, key, load_hours_bcd, load_minutes_bcd,
                  load_seconds_bcd, output ready);
endinterface

interface cte_rsp_if;
    logic valid;
    logic ready;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] cursor;
    logic       commit;
    logic [7:0] hours_bcd;
    logic [7:0] minutes_bcd;
    logic [7:0] seconds_bcd;

    modport source (output valid, hours, minutes, seconds, cursor, commit, hours_bcd,
                    minutes_bcd, seconds_bcd, input ready);
    modport sink (input valid, hours, minutes, seconds, cursor, commit, hours_bcd,
                  minutes_bcd, seconds_bcd, output ready);
endinterface

// ===== rtl/core/clock_time_remote_key_editor.sv =====
// Key-driven editor for a clock's hours, minutes and seconds. Each request is
// either a load (mode 0: packed decimal time in, cursor to hour tens) or a key
// press (cursor left/right, digit up/down, digit entry, confirm). Every request
// gives one response with the edited time in binary and packed decimal, the
// cursor and a commit flag set by the confirm key. A request passes an input
// register, then combinational edit logic that updates the time registers and
// loads the response register. A new request is taken every cycle while the
// response side keeps up.
module clock_time_remote_key_editor
    import cte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cte_req_if.sink   i_req,
    cte_rsp_if.source o_rsp
);

    logic    r_in_valid;
    t_req    r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    advance;

    // the edit stage fires when the response register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.mode             <= i_req.mode;
            r_in.key              <= i_req.key;
            r_in.load_hours_bcd   <= i_req.load_hours_bcd;
            r_in.load_minutes_bcd <= i_req.load_minutes_bcd;
            r_in.load_seconds_bcd <= i_req.load_seconds_bcd;
        end
    end

    // edit logic
    cte_edit u_edit (
        .i_req    (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // time and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hours       = r_out.hours;
    assign o_rsp.minutes     = r_out.minutes;
    assign o_rsp.seconds     = r_out.seconds;
    assign o_rsp.cursor      = r_out.cursor;
    assign o_rsp.commit      = r_out.commit;
    assign o_rsp.hours_bcd   = r_out.hours_bcd;
    assign o_rsp.minutes_bcd = r_out.minutes_bcd;
    assign o_rsp.seconds_bcd = r_out.seconds_bcd;

    // cursor stays on one of the six digits
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cursor <= LAST_POS)
        else $error("cursor out of range");

    // minutes and seconds stay below sixty, hours below thirty
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.minutes <= MINSEC_MAX && r_state.seconds <= MINSEC_MAX &&
        r_state.hours <= HOURS_EDIT_MAX)
        else $error("time value out of range");

    // a load puts the cursor on the hour tens
    a_load_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.mode |=> r_state.cursor == POS_HOUR_TENS)
        else $error("load did not reset cursor");

    // confirm leaves the time and cursor untouched
    a_confirm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.mode && r_in.key == KEY_CONFIRM |=> r_state == $past(r_state))
        else $error("confirm changed the time");

endmodule

// ===== rtl/core/cte_edit.sv =====
module cte_edit
    import cte_pkg::*;
(
    input  t_req    i_req,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    logic [5:0] hr6;
    logic [5:0] mn6;
    logic [5:0] sc6;
    logic [5:0] n_hr6;
    logic [5:0] n_mn6;
    logic [5:0] n_sc6;
    logic [2:0] n_cur;
    logic       n_commit;

    assign hr6 = {1'b0, i_state.hours};
    assign mn6 = i_state.minutes;
    assign sc6 = i_state.seconds;

    // key decode and per-digit edit rules
    always_comb begin
        n_hr6    = hr6;
        n_mn6    = mn6;
        n_sc6    = sc6;
        n_cur    = i_state.cursor;
        n_commit = 1'b0;
        if (!i_req.mode) begin
            n_hr6 = from_packed(i_req.load_hours_bcd, HOUR_MAX);
            n_mn6 = from_packed(i_req.load_minutes_bcd, MINSEC_MAX);
            n_sc6 = from_packed(i_req.load_seconds_bcd, MINSEC_MAX);
            n_cur = POS_HOUR_TENS;
        end else begin
            case (i_req.key)
                KEY_CONFIRM: n_commit = 1'b1;
                KEY_NONE: ;
                KEY_LEFT: begin
                    n_cur = (i_state.cursor == POS_HOUR_TENS || i_state.cursor > LAST_POS)
                          ? LAST_POS : 3'(i_state.cursor - 3'd1);
                end
                KEY_RIGHT: begin
                    n_cur = (i_state.cursor >= LAST_POS) ? POS_HOUR_TENS
                          : 3'(i_state.cursor + 3'd1);
                end
                KEY_UP: begin
                    case (i_state.cursor)
                        POS_HOUR_TENS:
                            n_hr6 = (hr6 >= HOUR_TENS_TOP) ? 6'(units_of(hr6)) : hr6 + TEN;
                        POS_HOUR_UNITS:
                            n_hr6 = (hr6 >= HOUR_MAX) ? 6'd0 : hr6 + 6'd1;
                        POS_MIN_TENS:
                            n_mn6 = (mn6 >= MINSEC_TENS_TOP) ? 6'(units_of(mn6)) : mn6 + TEN;
                        POS_MIN_UNITS:
                            n_mn6 = (mn6 >= MINSEC_MAX) ? 6'd0 : mn6 + 6'd1;
                        POS_SEC_TENS:
                            n_sc6 = (sc6 >= MINSEC_TENS_TOP) ? 6'(units_of(sc6)) : sc6 + TEN;
                        POS_SEC_UNITS:
                            n_sc6 = (sc6 >= MINSEC_MAX) ? 6'd0 : sc6 + 6'd1;
                        default: ;
                    endcase
                end
                KEY_DOWN: begin
                    case (i_state.cursor)
                        POS_HOUR_TENS:  n_hr6 = (hr6 <= TEN) ? HOUR_MAX : hr6 - TEN;
                        POS_HOUR_UNITS: n_hr6 = (hr6 == 6'd0) ? HOUR_MAX : hr6 - 6'd1;
                        POS_MIN_TENS:   n_mn6 = (mn6 <= TEN) ? MINSEC_MAX : mn6 - TEN;
                        POS_MIN_UNITS:  n_mn6 = (mn6 == 6'd0) ? MINSEC_MAX : mn6 - 6'd1;
                        POS_SEC_TENS:   n_sc6 = (sc6 <= TEN) ? MINSEC_MAX : sc6 - TEN;
                        POS_SEC_UNITS:  n_sc6 = (sc6 == 6'd0) ? MINSEC_MAX : sc6 - 6'd1;
                        default: ;
                    endcase
                end
                default: begin
                    // digit keys 0 to 9
                    case (i_state.cursor)
                        POS_HOUR_TENS: begin
                            if (i_req.key <= KEY_DIGIT_LIMIT_HOUR_TENS)
                                n_hr6 = 6'(6'(i_req.key) * TEN) + 6'(units_of(hr6));
                        end
                        POS_HOUR_UNITS: begin
                            if (hr6 < HOUR_TENS_TOP || i_req.key <= KEY_DIGIT_LIMIT_HOUR_UNITS)
                                n_hr6 = tens_times_ten(hr6) + 6'(i_req.key);
                        end
                        POS_MIN_TENS: begin
                            if (i_req.key <= KEY_DIGIT_LIMIT_TENS)
                                n_mn6 = 6'(6'(i_req.key) * TEN) + 6'(units_of(mn6));
                        end
                        POS_MIN_UNITS: n_mn6 = tens_times_ten(mn6) + 6'(i_req.key);
                        POS_SEC_TENS: begin
                            if (i_req.key <= KEY_DIGIT_LIMIT_TENS)
                                n_sc6 = 6'(6'(i_req.key) * TEN) + 6'(units_of(sc6));
                        end
                        POS_SEC_UNITS: n_sc6 = tens_times_ten(sc6) + 6'(i_req.key);
                        default: ;
                    endcase
                end
            endcase
        end
    end

    // next state and result record
    always_comb begin
        o_state.hours   = n_hr6[4:0];
        o_state.minutes = n_mn6;
        o_state.seconds = n_sc6;
        o_state.cursor  = n_cur;

        o_result.hours       = n_hr6[4:0];
        o_result.minutes     = n_mn6;
        o_result.seconds     = n_sc6;
        o_result.cursor      = n_cur;
        o_result.commit      = n_commit;
        o_result.hours_bcd   = to_packed({1'b0, n_hr6[4:0]});
        o_result.minutes_bcd = to_packed(n_mn6);
        o_result.seconds_bcd = to_packed(n_sc6);
    end

endmodule
